/* sv/xxh_pkg.sv */
// Shared constants, types and helpers for the XXH64 stripe hasher.
`timescale 1ns / 1ps
package xxh_pkg;
    localparam logic [63:0] PRIME_A = 64'd11400714785074694791;
    localparam logic [63:0] PRIME_B = 64'd14029467366897019727;
    localparam logic [63:0] PRIME_C = 64'd1609587929392839161;
    localparam logic [63:0] PRIME_D = 64'd9650029242287828579;
    localparam logic [63:0] PRIME_E = 64'd2870177450012600261;
    localparam int unsigned LANES = 4;
    localparam logic [5:0] STRIPE_BYTES = 6'd32;

    typedef logic [63:0] word_t;
    typedef word_t [LANES-1:0] stripe_t;

    function automatic word_t rol64(input word_t x, input int unsigned n);
        rol64 = (x << n) | (x >> (64 - n));
    endfunction
endpackage

/* sv/xxh_mul64.sv */
// Iterative 64x64 multiplier, low 64 bits, one 32x32 partial product per cycle.
`timescale 1ns / 1ps
module xxh_mul64 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  xxh_pkg::word_t a,
    input  xxh_pkg::word_t b,
    output logic          done,
    output xxh_pkg::word_t prod
);
    import xxh_pkg::*;

    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    word_t       acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_x, op_y;
    logic [63:0] pp;

    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
        pp = {32'b0, op_x} * {32'b0, op_y};
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (cnt_reg == 2'd0)
                acc_next = pp;
            else
                acc_next = acc_reg + {pp[31:0], 32'b0};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            a_next    = a;
            b_next    = b;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* sv/xxh_lane.sv */
// One lane round: rol(acc + w*B, 31) * A, on a shared iterative multiplier.
`timescale 1ns / 1ps
module xxh_lane (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  xxh_pkg::word_t acc,
    input  xxh_pkg::word_t w,
    output logic          done,
    output xxh_pkg::word_t result
);
    import xxh_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL1 = 2'd1;
    localparam logic [1:0] L_MUL2 = 2'd2;

    logic [1:0] st_reg, st_next;
    word_t      acc_reg, acc_next;
    logic       m_start, m_done;
    word_t      m_a, m_b, m_prod;

    xxh_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m_start),
        .a     (m_a),
        .b     (m_b),
        .done  (m_done),
        .prod  (m_prod)
    );

    always_comb
    begin
        st_next  = st_reg;
        acc_next = acc_reg;
        m_start  = 1'b0;
        m_a      = w;
        m_b      = PRIME_B;
        done     = 1'b0;
        case (st_reg)
            L_IDLE:
                if (start)
                begin
                    acc_next = acc;
                    m_start  = 1'b1;
                    st_next  = L_MUL1;
                end
            L_MUL1:
                if (m_done)
                begin
                    m_a     = rol64(acc_reg + m_prod, 31);
                    m_b     = PRIME_A;
                    m_start = 1'b1;
                    st_next = L_MUL2;
                end
            L_MUL2:
                if (m_done)
                begin
                    done    = 1'b1;
                    st_next = L_IDLE;
                end
            default:
                st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= L_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign result = m_prod;
endmodule

/* sv/xxh_final.sv */
// Merge, length add, tail folding and avalanche sequencer.
`timescale 1ns / 1ps
module xxh_final (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            merge,
    input  xxh_pkg::stripe_t acc,
    input  xxh_pkg::stripe_t rnd,
    input  xxh_pkg::stripe_t words,
    input  logic [5:0]      n,
    input  xxh_pkg::word_t   total,
    input  logic            out_free,
    output logic            busy,
    output logic            fin_valid,
    output xxh_pkg::word_t   fin_hash
);
    import xxh_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MRG_X = 4'd1;
    localparam logic [3:0] S_MRG_W = 4'd2;
    localparam logic [3:0] S_TAIL  = 4'd3;
    localparam logic [3:0] S_W1    = 4'd4;
    localparam logic [3:0] S_W2    = 4'd5;
    localparam logic [3:0] S_W3    = 4'd6;
    localparam logic [3:0] S_H1    = 4'd7;
    localparam logic [3:0] S_H2    = 4'd8;
    localparam logic [3:0] S_B1    = 4'd9;
    localparam logic [3:0] S_B2    = 4'd10;
    localparam logic [3:0] S_A1    = 4'd11;
    localparam logic [3:0] S_A2    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] st_reg, st_next;
    word_t      h_reg, h_next;
    logic [5:0] p_reg, p_next;
    logic [1:0] i_reg, i_next;
    logic       m_start, m_done;
    word_t      m_a, m_b, m_prod;
    word_t      wsel, bsel, tmp;
    logic [6:0] p_ext;

    xxh_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m_start),
        .a     (m_a),
        .b     (m_b),
        .done  (m_done),
        .prod  (m_prod)
    );

    assign wsel  = words[p_reg[4:3]];
    assign bsel  = {56'b0, 8'(wsel >> {p_reg[2:0], 3'b000})};
    assign p_ext = {1'b0, p_reg};

    always_comb
    begin
        st_next = st_reg;
        h_next  = h_reg;
        p_next  = p_reg;
        i_next  = i_reg;
        m_start = 1'b0;
        m_a     = h_reg;
        m_b     = PRIME_A;
        tmp     = h_reg;
        case (st_reg)
            S_IDLE:
                if (start)
                begin
                    // merged path adds the length after the four merge rounds
                    if (merge)
                        h_next = rol64(acc[0], 1) + rol64(acc[1], 7) + rol64(acc[2], 12)
                               + rol64(acc[3], 18);
                    else
                        h_next = acc[2] + PRIME_E + total;
                    p_next  = 6'd0;
                    i_next  = 2'd0;
                    st_next = merge ? S_MRG_X : S_TAIL;
                end
            S_MRG_X:
            begin
                m_a     = h_reg ^ rnd[i_reg];
                m_start = 1'b1;
                st_next = S_MRG_W;
            end
            S_MRG_W:
                if (m_done)
                begin
                    h_next  = m_prod + PRIME_D;
                    if (i_reg == 2'd3)
                        h_next = m_prod + PRIME_D + total;
                    i_next  = i_reg + 2'd1;
                    st_next = (i_reg == 2'd3) ? S_TAIL : S_MRG_X;
                end
            S_TAIL:
            begin
                m_start = 1'b1;
                if (p_ext + 7'd8 <= {1'b0, n})
                begin
                    m_a     = wsel;
                    m_b     = PRIME_B;
                    st_next = S_W1;
                end
                else if (p_ext + 7'd4 <= {1'b0, n})
                begin
                    m_a     = {32'b0, wsel[31:0]};
                    st_next = S_H1;
                end
                else if (p_reg < n)
                begin
                    m_a     = bsel;
                    m_b     = PRIME_E;
                    st_next = S_B1;
                end
                else
                begin
                    m_a     = h_reg ^ (h_reg >> 33);
                    m_b     = PRIME_B;
                    st_next = S_A1;
                end
            end
            S_W1:
                if (m_done)
                begin
                    m_a     = rol64(m_prod, 31);
                    m_start = 1'b1;
                    st_next = S_W2;
                end
            S_W2:
                if (m_done)
                begin
                    m_a     = rol64(h_reg ^ m_prod, 27);
                    m_start = 1'b1;
                    st_next = S_W3;
                end
            S_W3:
                if (m_done)
                begin
                    h_next  = m_prod + PRIME_D;
                    p_next  = p_reg + 6'd8;
                    st_next = S_TAIL;
                end
            S_H1:
                if (m_done)
                begin
                    m_a     = rol64(h_reg ^ m_prod, 23);
                    m_b     = PRIME_B;
                    m_start = 1'b1;
                    st_next = S_H2;
                end
            S_H2:
                if (m_done)
                begin
                    h_next  = m_prod + PRIME_C;
                    p_next  = p_reg + 6'd4;
                    st_next = S_TAIL;
                end
            S_B1:
                if (m_done)
                begin
                    m_a     = rol64(h_reg ^ m_prod, 11);
                    m_start = 1'b1;
                    st_next = S_B2;
                end
            S_B2:
                if (m_done)
                begin
                    h_next  = m_prod;
                    p_next  = p_reg + 6'd1;
                    st_next = S_TAIL;
                end
            S_A1:
                if (m_done)
                begin
                    m_a     = m_prod ^ (m_prod >> 29);
                    m_b     = PRIME_C;
                    m_start = 1'b1;
                    st_next = S_A2;
                end
            S_A2:
                if (m_done)
                begin
                    tmp     = m_prod ^ (m_prod >> 32);
                    h_next  = tmp;
                    st_next = S_DONE;
                end
            S_DONE:
                if (out_free)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        p_reg <= p_next;
        i_reg <= i_next;
    end

    assign busy      = (st_reg != S_IDLE);
    assign fin_valid = (st_reg == S_DONE);
    assign fin_hash  = h_reg;
endmodule

/* sv/xxhash64_stripe_hasher.sv */
// Top level of the XXH64 stripe hasher: lanes, finisher and handshakes.
// Usage:
//   Input channel (in_valid/in_ready): one request per 32-byte stripe,
//   word0..word3 little-endian, byte_count valid bytes, last ends a message.
//   Requests without last are absorbed as full stripes.
//   Output channel (out_valid/out_ready): one hash per last request.
//   Config: cfg_wr_en/cfg_wr_data loads the seed, re-arms the lanes and
//   drops any message in progress; write only while idle.
// Operation:
//   Each multiply runs on a 32x32 iterative unit.
//   A stripe takes two dependent multiplies per lane, all four lanes in
//   parallel.
//   A last request adds the lane merge rounds (only when 32 or more bytes
//   were absorbed), four merge multiplies, up to 3 word folds (3 multiplies
//   each), at most one half fold and up to 3 byte folds (2 each), and 2
//   avalanche multiplies before out_valid.
// Reset: lanes armed from seed 0, byte count cleared, no result pending.
// Stall: the hash waits in the output register; the next request is still
//   taken and absorbed, but the finisher holds its result until the
//   register frees, and no further request is taken meanwhile.
`timescale 1ns / 1ps
module xxhash64_stripe_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  xxh_pkg::word_t         cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  xxh_pkg::word_t         word0,
    input  xxh_pkg::word_t         word1,
    input  xxh_pkg::word_t         word2,
    input  xxh_pkg::word_t         word3,
    input  logic [5:0]            byte_count,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output xxh_pkg::word_t         hash
);
    import xxh_pkg::*;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_ABS  = 3'd1;
    localparam logic [2:0] T_PRE  = 3'd2;
    localparam logic [2:0] T_MRG  = 3'd3;
    localparam logic [2:0] T_FIN  = 3'd4;

    logic [2:0] st_reg, st_next;
    word_t      seed_reg, seed_next;
    stripe_t    acc_reg, acc_next;
    stripe_t    rnd_reg, rnd_next;
    stripe_t    w_reg, w_next;
    logic [5:0] n_reg, n_next;
    logic       last_reg, last_next;
    word_t      total_reg, total_next;
    logic       ov_reg, ov_next;
    word_t      hash_reg, hash_next;

    logic       lane_start, fin_start, fin_busy, fin_valid, out_free;
    stripe_t    lane_acc_in, lane_w_in, lane_res;
    logic [LANES-1:0] lane_done;
    word_t      fin_hash;
    logic [5:0] n_clamp;

    // Four parallel lane round engines; the same engines do the merge rounds.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        xxh_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start),
            .acc    (lane_acc_in[g]),
            .w      (lane_w_in[g]),
            .done   (lane_done[g]),
            .result (lane_res[g])
        );
    end

    xxh_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fin_start),
        .merge     (total_reg >= 64'd32),
        .acc       (acc_reg),
        .rnd       (rnd_reg),
        .words     (w_reg),
        .n         (n_reg),
        .total     (total_reg),
        .out_free  (out_free),
        .busy      (fin_busy),
        .fin_valid (fin_valid),
        .fin_hash  (fin_hash)
    );

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (st_reg == T_IDLE);
    assign n_clamp  = (byte_count > STRIPE_BYTES) ? STRIPE_BYTES : byte_count;

    always_comb
    begin
        st_next    = st_reg;
        seed_next  = seed_reg;
        acc_next   = acc_reg;
        rnd_next   = rnd_reg;
        w_next     = w_reg;
        n_next     = n_reg;
        last_next  = last_reg;
        total_next = total_reg;
        lane_start = 1'b0;
        fin_start  = 1'b0;
        lane_acc_in = acc_reg;
        lane_w_in   = w_reg;

        case (st_reg)
            T_IDLE:
                if (in_valid)
                begin
                    w_next    = '{word3, word2, word1, word0};
                    last_next = last;
                    n_next    = n_clamp;
                    if (!last || n_clamp == STRIPE_BYTES)
                    begin
                        lane_w_in  = '{word3, word2, word1, word0};
                        lane_start = 1'b1;
                        st_next    = T_ABS;
                    end
                    else
                    begin
                        total_next = total_reg + {58'b0, n_clamp};
                        st_next    = T_PRE;
                    end
                end
            T_ABS:
                if (lane_done[0])
                begin
                    acc_next   = lane_res;
                    total_next = total_reg + {58'b0, STRIPE_BYTES};
                    n_next     = 6'd0;
                    st_next    = last_reg ? T_PRE : T_IDLE;
                end
            T_PRE:
                if (total_reg >= 64'd32)
                begin
                    lane_acc_in = '0;
                    lane_w_in   = acc_reg;
                    lane_start  = 1'b1;
                    st_next     = T_MRG;
                end
                else
                begin
                    fin_start = 1'b1;
                    st_next   = T_FIN;
                end
            T_MRG:
                if (lane_done[0])
                begin
                    rnd_next  = lane_res;
                    fin_start = 1'b1;
                    st_next   = T_FIN;
                end
            T_FIN:
                if (!fin_busy)
                begin
                    acc_next   = '{seed_reg - PRIME_A, seed_reg, seed_reg + PRIME_B,
                                   seed_reg + PRIME_A + PRIME_B};
                    total_next = '0;
                    st_next    = T_IDLE;
                end
            default:
                st_next = T_IDLE;
        endcase

        // Seed write re-arms; the user must issue it only while idle, the block does not enforce it.
        if (cfg_wr_en)
        begin
            seed_next  = cfg_wr_data;
            acc_next   = '{cfg_wr_data - PRIME_A, cfg_wr_data, cfg_wr_data + PRIME_B,
                           cfg_wr_data + PRIME_A + PRIME_B};
            total_next = '0;
        end
    end

    // Output register
    always_comb
    begin
        ov_next   = ov_reg;
        hash_next = hash_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (fin_valid && out_free)
        begin
            ov_next   = 1'b1;
            hash_next = fin_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= T_IDLE;
            seed_reg  <= '0;
            acc_reg   <= '{64'd0 - PRIME_A, 64'd0, PRIME_B, PRIME_A + PRIME_B};
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            seed_reg  <= seed_next;
            acc_reg   <= acc_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg  <= rnd_next;
        w_reg    <= w_next;
        n_reg    <= n_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

    assign out_valid = ov_reg;
    assign hash      = hash_reg;
endmodule

/* sim/xxhash64_stripe_hasher_tb.sv */
// Testbench for the XXH64 stripe hasher: directed and random messages checked against a local model.
`timescale 1ns / 1ps
module xxhash64_stripe_hasher_tb;
    import xxh_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    word_t      cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    word_t      word0, word1, word2, word3;
    logic [5:0] byte_count;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    word_t      hash;

    // Model state: seed, lane accumulators and absorbed length.
    word_t      model_seed;
    word_t      model_lane [4];
    word_t      model_len;

    word_t      pending_hashes [$];
    int         mismatches;
    int         hashes_seen;
    int         requests_sent;
    int         messages_sent;
    longint     cycle_count;
    bit         hold_off;       // long receiver stall in effect
    bit         stall_enable;   // random receiver stalls allowed
    bit         gaps_enable;    // random sender gaps allowed

    xxhash64_stripe_hasher u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .word0      (word0),
        .word1      (word1),
        .word2      (word2),
        .word3      (word3),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash       (hash)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Hash model
    // ---------------------------------------------------------------
    function automatic word_t rotl(input word_t x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic word_t mix_round(input word_t acc, input word_t w);
        acc = acc + w * PRIME_B;
        acc = rotl(acc, 31);
        return acc * PRIME_A;
    endfunction

    function automatic void rearm_lanes();
        model_lane[0] = model_seed + PRIME_A + PRIME_B;
        model_lane[1] = model_seed + PRIME_B;
        model_lane[2] = model_seed;
        model_lane[3] = model_seed - PRIME_A;
        model_len = '0;
    endfunction

    function automatic void absorb_stripe(input word_t w [4]);
        for (int i = 0; i < 4; i++)
            model_lane[i] = mix_round(model_lane[i], w[i]);
        model_len = model_len + 64'd32;
    endfunction

    function automatic word_t digest_tail(input word_t w [4], input int n);
        word_t h;
        word_t k;
        int    p;
        p = 0;
        if (model_len >= 64'd32)
        begin
            h = rotl(model_lane[0], 1) + rotl(model_lane[1], 7) +
                rotl(model_lane[2], 12) + rotl(model_lane[3], 18);
            for (int i = 0; i < 4; i++)
            begin
                h = h ^ mix_round('0, model_lane[i]);
                h = h * PRIME_A + PRIME_D;
            end
        end
        else
            h = model_lane[2] + PRIME_E;
        h = h + model_len;
        while (p + 8 <= n)
        begin
            h = h ^ mix_round('0, w[p >> 3]);
            h = rotl(h, 27) * PRIME_A + PRIME_D;
            p += 8;
        end
        if (p + 4 <= n)
        begin
            k = w[p >> 3] & 64'hFFFF_FFFF;
            h = h ^ (k * PRIME_A);
            h = rotl(h, 23) * PRIME_B + PRIME_C;
            p += 4;
        end
        while (p < n)
        begin
            k = (w[(p >> 3) & 3] >> (8 * (p & 7))) & 64'hFF;
            h = h ^ (k * PRIME_E);
            h = rotl(h, 11) * PRIME_A;
            p++;
        end
        h = h ^ (h >> 33);
        h = h * PRIME_B;
        h = h ^ (h >> 29);
        h = h * PRIME_C;
        h = h ^ (h >> 32);
        return h;
    endfunction

    // Advance the model by one request; queue a digest when it ends a message.
    function automatic void predict_request(input word_t w [4], input logic [5:0] cnt,
                                            input logic fin);
        int n;
        if (!fin)
        begin
            absorb_stripe(w);
            return;
        end
        n = (cnt > 6'd32) ? 32 : int'(cnt);
        if (n == 32)
        begin
            absorb_stripe(w);
            n = 0;
        end
        else
            model_len = model_len + word_t'(n);
        pending_hashes.push_back(digest_tail(w, n));
        rearm_lanes();
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    task automatic send_request(input word_t w [4], input logic [5:0] cnt, input logic fin);
        int gap;
        if (gaps_enable && $urandom_range(0, 3) == 0)
        begin
            // burst ends: idle a random gap
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        word0      <= w[0];
        word1      <= w[1];
        word2      <= w[2];
        word3      <= w[3];
        byte_count <= cnt;
        last       <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(w, cnt, fin);
        requests_sent++;
        if (fin)
            messages_sent++;
        in_valid <= 1'b0;
        // block is busy after a request anyway
        @(posedge clk);
    endtask

    // Let the pipeline drain before touching the seed.
    task automatic wait_idle();
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input word_t s);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_seed = s;
        rearm_lanes();
    endtask

    function automatic word_t rand_word();
        word_t v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic send_message(input int stripes, input logic [5:0] tail_cnt);
        word_t w [4];
        for (int s = 0; s <= stripes; s++)
        begin
            for (int i = 0; i < 4; i++)
                w[i] = rand_word();
            if (s < stripes)
                // non-last requests may carry any count; it is ignored
                send_request(w, 6'($urandom_range(0, 63)), 1'b0);
            else
                send_request(w, tail_cnt, 1'b1);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        word_t w [4];
        w = '{default: '0};
        send_request(w, 6'd0, 1'b1);          // empty message
        w = '{default: '1};
        send_request(w, 6'd32, 1'b1);         // single full stripe as last
        send_request(w, 6'd63, 1'b1);         // oversized count clamps to 32
        for (int n = 1; n <= 31; n += 3)
            send_message(0, 6'(n));           // short messages, every tail fold mix
        send_message(1, 6'd0);                // lane merge with empty tail
        send_message(2, 6'd31);               // merge plus all tail folds
        send_message(1, 6'd12);
    endtask

    task automatic test_seeds();
        load_seed('1);
        send_message(0, 6'd5);
        send_message(1, 6'd20);
        load_seed(64'h8000_0000_0000_0000);
        send_message(0, 6'd0);
        send_message(2, 6'd7);
        // seed write in the middle of a message drops it
        wait_idle();
        begin
            word_t w [4];
            for (int i = 0; i < 4; i++)
                w[i] = rand_word();
            send_request(w, 6'd32, 1'b0);
        end
        load_seed({$urandom(), $urandom()});
        send_message(1, 6'd9);
    endtask

    task automatic test_backpressure();
        // receiver holds off while sender keeps offering
        gaps_enable = 1'b0;
        hold_off = 1'b1;
        for (int m = 0; m < 8; m++)
            send_message(0, 6'($urandom_range(0, 32)));
        wait (hold_off == 1'b0);
        // sender pauses until every result is back
        while (pending_hashes.size() != 0)
            @(posedge clk);
        gaps_enable = 1'b1;
    endtask

    task automatic test_random();
        int stripes;
        int phase;
        phase = 0;
        while (requests_sent < 1050)
        begin
            // mostly short messages, occasionally long ones
            stripes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(0, 2);
            send_message(stripes, 6'($urandom_range(0, 33)));
            if (requests_sent / 350 != phase)
            begin
                phase = requests_sent / 350;
                stall_enable = ~stall_enable;
                gaps_enable  = ~gaps_enable;
                if (phase == 2)
                    load_seed('0);
                else
                    load_seed({$urandom(), $urandom()});
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall pattern, plus an occasional long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (stall_enable)
                out_ready <= ($urandom_range(0, 2) != 0);
            else
                out_ready <= 1'b1;
        end
    end

    // Result checker: compare each accepted hash with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            hashes_seen++;
            if (pending_hashes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected hash %h", hash);
            end
            else
            begin
                word_t want;
                want = pending_hashes.pop_front();
                if (hash !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: hash %0d expected %h got %h",
                                 hashes_seen, want, hash);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        word0        = '0;
        word1        = '0;
        word2        = '0;
        word3        = '0;
        byte_count   = '0;
        last         = 1'b0;
        mismatches   = 0;
        hashes_seen  = 0;
        requests_sent = 0;
        messages_sent = 0;
        cycle_count  = 0;
        hold_off     = 1'b0;
        stall_enable = 1'b1;
        gaps_enable  = 1'b1;
        model_seed   = '0;
        rearm_lanes();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_seeds();
        test_backpressure();
        test_random();

        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_hashes.size() != 0)
            mismatches++;

        $display("Sent %0d requests in %0d messages, checked %0d hashes",
                 requests_sent, messages_sent, hashes_seen);
        $display("Covered empty/short/multi-stripe messages, seed changes, stalls");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
